// ----- design/page_table_identity_mapper_core_assert.svh -----
// Assertion macros for the identity mapper core.
`ifndef PAGE_TABLE_IDENTITY_MAPPER_CORE_ASSERT_SVH
`define PAGE_TABLE_IDENTITY_MAPPER_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define PTIM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define PTIM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ptim_pkg.sv -----
`default_nettype none
package ptim_pkg;
    localparam int unsigned PageW   = 36;
    localparam int unsigned CountW  = 20;
    localparam int unsigned AddrW   = 48;
    localparam int unsigned SlotW   = 9;
    localparam int unsigned Slots   = 512;
    localparam int unsigned PoolTablesDefault = 16;

    localparam logic [63:0] PteP   = 64'h1;
    localparam logic [63:0] PteRw  = 64'h2;
    localparam logic [63:0] PteUs  = 64'h4;
    localparam logic [63:0] PtePwt = 64'h8;
    localparam logic [63:0] PtePcd = 64'h10;
    localparam logic [63:0] PtePs  = 64'h80;
    localparam logic [63:0] Addr4k = 64'h0000_ffff_ffff_f000;
    localparam logic [63:0] Addr2m = 64'h0000_ffff_ffe0_0000;

    localparam logic [1:0] StDone  = 2'd0;
    localparam logic [1:0] StMapped = 2'd1;
    localparam logic [1:0] StPool  = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PAGE,
        S_READ,
        S_WAIT,
        S_EVAL,
        S_FILL,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

// ----- design/page_table_identity_mapper_core.sv -----
`default_nettype none
// Identity mapper for a four-level x86-64 page table tree kept in an on-chip pool.
// Command channel: pulse i_start with the range and leaf flags while o_busy is low;
// o_busy rises the next cycle and stays high until the result. The result
// (o_status, o_stop_page, o_pages_left) is shown for one cycle with o_done high;
// the receiver cannot stall and must take it then.
// Config: APB register 0 at byte 0 is pool_base_address, 64-bit data, bits 47:0 kept, 47:12 used.
// Walk: each page starts its walk in S_PAGE, then each walk level passes read, memory
// wait and evaluate/write; a 2 MiB entry walks three levels and a 4 KiB entry four.
// Each new table adds a clearing sweep over its 512 slots, and a request closes
// through S_DONE. One request runs at a time; a new i_start is taken only while idle.
// Reset: a sweep clears the 512 slots of the root table; o_busy stays high meanwhile.
// The next-free-table count returns to one.
module page_table_identity_mapper_core #(
    parameter int unsigned POOL_TABLES = ptim_pkg::PoolTablesDefault
) (
    input  wire  logic                          i_clk,
    input  wire  logic                          i_rst_n,
    input  wire  logic                          i_start,
    output logic                                o_busy,
    input  wire  logic [ptim_pkg::PageW-1:0]    i_base_page,
    input  wire  logic [ptim_pkg::CountW-1:0]   i_page_count,
    input  wire  logic                          i_writable,
    input  wire  logic                          i_user_access,
    input  wire  logic                          i_write_through,
    input  wire  logic                          i_cache_disable,
    output logic                                o_done,
    output logic [1:0]                          o_status,
    output logic [ptim_pkg::PageW-1:0]          o_stop_page,
    output logic [ptim_pkg::CountW-1:0]         o_pages_left,
    input  wire  logic                          psel,
    input  wire  logic                          penable,
    input  wire  logic                          pwrite,
    input  wire  logic [0:0]                    paddr,
    input  wire  logic [63:0]                   pwdata,
    output logic [63:0]                         prdata,
    output logic                                pready
);
    import ptim_pkg::*;
    `include "page_table_identity_mapper_core_assert.svh"

    localparam int unsigned TblW  = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int unsigned CntW  = $clog2(POOL_TABLES + 1);
    localparam int unsigned MemW  = TblW + SlotW;
    localparam int unsigned Depth = POOL_TABLES * Slots;

    logic [63:0] r_mem [Depth];
    logic [63:0] r_rdata;

    t_state             r_state, n_state;
    logic [AddrW-1:0]   r_pool;
    logic [CntW-1:0]    r_free, n_free;
    logic [PageW-1:0]   r_pg, n_pg;
    logic [CountW-1:0]  r_left, n_left;
    logic [63:0]        r_flags, n_flags;
    logic [1:0]         r_lvl, n_lvl;
    logic               r_large, n_large;
    logic [TblW-1:0]    r_tbl, n_tbl;
    logic [1:0]         r_st, n_st;
    logic [SlotW-1:0]   r_ccnt, n_ccnt;
    logic [TblW-1:0]    r_ctbl, n_ctbl;

    logic               mem_we;
    logic [MemW-1:0]    mem_addr;
    logic [63:0]        mem_wdata;

    logic               cfg_wr;
    logic [SlotW-1:0]   slot;
    logic [AddrW-1:0]   pbase;
    logic [AddrW-1:0]   off;
    logic [AddrW-1:0]   new_addr;
    logic [AddrW-1:0]   leaf_addr;
    logic [CountW:0]    step;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr == 1'b0) ? {16'd0, r_pool} : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= '0;
        end else if (cfg_wr && paddr == 1'b0) begin
            r_pool <= pwdata[AddrW-1:0];
        end
    end

    assign pbase = {r_pool[AddrW-1:12], 12'd0};

    always_comb begin
        unique case (r_lvl)
            2'd0:    slot = r_pg[35:27];
            2'd1:    slot = r_pg[26:18];
            2'd2:    slot = r_pg[17:9];
            default: slot = r_pg[8:0];
        endcase
    end

    assign off       = (r_rdata[AddrW-1:0] & Addr4k[AddrW-1:0]) - pbase;
    assign new_addr  = pbase + {{(AddrW-12-CntW){1'b0}}, r_free, 12'd0};
    assign leaf_addr = {r_pg, 12'd0};
    assign step      = r_large ? (CountW+1)'(Slots) : (CountW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wdata;
        r_rdata <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_free  <= CntW'(1);
            r_ccnt  <= '0;
            r_ctbl  <= '0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_ccnt  <= n_ccnt;
            r_ctbl  <= n_ctbl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pg    <= n_pg;
        r_left  <= n_left;
        r_flags <= n_flags;
        r_lvl   <= n_lvl;
        r_large <= n_large;
        r_tbl   <= n_tbl;
        r_st    <= n_st;
    end

    always_comb begin
        n_state   = r_state;
        n_free    = r_free;
        n_pg      = r_pg;
        n_left    = r_left;
        n_flags   = r_flags;
        n_lvl     = r_lvl;
        n_large   = r_large;
        n_tbl     = r_tbl;
        n_st      = r_st;
        n_ccnt    = r_ccnt;
        n_ctbl    = r_ctbl;
        mem_we    = 1'b0;
        mem_addr  = {r_tbl, slot};
        mem_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = {r_ctbl, r_ccnt};
                n_ccnt   = r_ccnt + SlotW'(1);
                if (r_ccnt == SlotW'(Slots - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_pg    = i_base_page;
                    n_left  = i_page_count;
                    n_flags = PteP | (i_writable ? PteRw : '0) | (i_user_access ? PteUs : '0)
                            | (i_write_through ? PtePwt : '0)
                            | (i_cache_disable ? PtePcd : '0);
                    n_st    = StDone;
                    n_state = S_PAGE;
                end
            end
            S_PAGE: begin
                // begin one leaf walk from the root
                if (r_left == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_large = (r_pg[8:0] == '0) && (r_left >= CountW'(Slots));
                    n_lvl   = 2'd0;
                    n_tbl   = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                mem_addr = {r_tbl, slot};
                if ((r_lvl == 2'd3) || (r_lvl == 2'd2 && r_large)) begin
                    if (r_rdata[0]) begin
                        n_st = StMapped; n_state = S_DONE;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = r_large
                            ? ({16'd0, leaf_addr} & Addr2m) | r_flags | PtePs
                            : ({16'd0, leaf_addr} & Addr4k) | r_flags;
                        n_pg      = r_pg + PageW'(step);
                        n_left    = r_left - step[CountW-1:0];
                        n_state   = S_PAGE;
                    end
                end else if (r_rdata[0]) begin
                    if (r_rdata[7]) begin
                        n_st = StMapped; n_state = S_DONE;
                    end else if (off[AddrW-1:12] >= (AddrW-12)'(r_free)) begin
                        n_st = StPool; n_state = S_DONE;
                    end else begin
                        n_tbl   = off[TblW+11:12];
                        n_lvl   = r_lvl + 2'd1;
                        n_state = S_READ;
                    end
                end else if (r_free >= CntW'(POOL_TABLES)) begin
                    n_st = StPool; n_state = S_DONE;
                end else begin
                    // link new table, then clear it before descending
                    mem_we    = 1'b1;
                    mem_wdata = ({16'd0, new_addr} & Addr4k) | PteP | PteRw;
                    n_ctbl    = r_free[TblW-1:0];
                    n_ccnt    = '0;
                    n_free    = r_free + CntW'(1);
                    n_state   = S_FILL;
                end
            end
            S_FILL: begin
                mem_we   = 1'b1;
                mem_addr = {r_ctbl, r_ccnt};
                n_ccnt   = r_ccnt + SlotW'(1);
                if (r_ccnt == SlotW'(Slots - 1)) begin
                    n_tbl   = r_ctbl;
                    n_lvl   = r_lvl + 2'd1;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = (r_state == S_DONE);
    assign o_status     = r_st;
    assign o_stop_page  = r_pg;
    assign o_pages_left = r_left;

    `PTIM_ASSERT_IMP(a_free_bound, i_clk, i_rst_n, 1'b1,
        r_free <= CntW'(POOL_TABLES), "pool count overflow")
    `PTIM_ASSERT_IMP(a_done_left, i_clk, i_rst_n, o_done && r_st == StDone,
        r_left == '0, "done with pages left")
    `PTIM_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy,
        o_busy, "start not taken")
    `PTIM_ASSERT_IMP(a_clear_idle, i_clk, i_rst_n, r_state == S_FILL,
        !o_done, "result during clear")
endmodule
`default_nettype wire

// ----- test/page_table_identity_mapper_core_tb.sv -----
`timescale 1ns / 100ps
module page_table_identity_mapper_core_tb;
    import ptim_pkg::*;

    localparam int unsigned PoolTables = 16;
    localparam logic [63:0] Addr48 = 64'h0000_ffff_ffff_ffff;

    typedef struct {
        logic [PageW-1:0]  page;
        logic [CountW-1:0] count;
        logic              wr;
        logic              us;
        logic              wt;
        logic              cd;
        bit                drain_first;
    } t_map_req;

    typedef struct {
        logic [1:0]        status;
        logic [PageW-1:0]  stop_page;
        logic [CountW-1:0] pages_left;
    } t_map_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic [PageW-1:0] i_base_page = '0;
    logic [CountW-1:0] i_page_count = '0;
    logic i_writable = 1'b0, i_user_access = 1'b0;
    logic i_write_through = 1'b0, i_cache_disable = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [0:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic o_busy, o_done, pready;
    logic [1:0] o_status;
    logic [PageW-1:0] o_stop_page;
    logic [CountW-1:0] o_pages_left;
    logic [63:0] prdata;

    page_table_identity_mapper_core #(.POOL_TABLES(PoolTables)) u_top (.*);

    always #4 i_clk = ~i_clk;

    // shadow of the table pool
    logic [63:0] shadow_mem [PoolTables*Slots];
    int unsigned tables_used;
    logic [63:0] pool_reg;

    t_map_req req_q[$];
    t_map_rsp rsp_q[$];
    t_map_req cur_req;
    int unsigned idle_pct;
    int unsigned errors = 0;

    function automatic logic [1:0] walk_link(input int unsigned tbl, input logic [8:0] slot,
                                             output int unsigned child);
        logic [63:0] e, off, base;
        int unsigned n;
        base = pool_reg & Addr4k;
        e = shadow_mem[tbl*Slots + slot];
        child = 0;
        if (e & PteP) begin
            if (e & PtePs) return StMapped;
            off = (((e & Addr4k) - base) & Addr48) >> 12;
            if (off >= tables_used) return StPool;
            child = 32'(off);
            return StDone;
        end
        if (tables_used >= PoolTables) return StPool;
        n = tables_used;
        tables_used++;
        for (int i = 0; i < Slots; i++) shadow_mem[n*Slots + i] = '0;
        shadow_mem[tbl*Slots + slot] = ((base + (64'(n) << 12)) & Addr4k) | PteP | PteRw;
        child = n;
        return StDone;
    endfunction

    function automatic logic [1:0] map_leaf(input logic [PageW-1:0] pg, input bit big,
                                            input logic [63:0] flags);
        int unsigned pdpt, pd, pt, at;
        logic [1:0] r;
        logic [63:0] addr;
        addr = (64'(pg) << 12) & Addr48;
        r = walk_link(0, pg[35:27], pdpt);
        if (r != StDone) return r;
        r = walk_link(pdpt, pg[26:18], pd);
        if (r != StDone) return r;
        if (big) begin
            at = pd*Slots + pg[17:9];
            if (shadow_mem[at] & PteP) return StMapped;
            shadow_mem[at] = (addr & Addr2m) | flags | PtePs;
            return StDone;
        end
        r = walk_link(pd, pg[17:9], pt);
        if (r != StDone) return r;
        at = pt*Slots + pg[8:0];
        if (shadow_mem[at] & PteP) return StMapped;
        shadow_mem[at] = (addr & Addr4k) | flags;
        return StDone;
    endfunction

    function automatic t_map_rsp map_range(input t_map_req rq);
        t_map_rsp rs;
        logic [63:0] flags;
        logic [PageW-1:0] pg;
        logic [CountW-1:0] left;
        bit big;
        flags = PteP | (rq.wr ? PteRw : 0) | (rq.us ? PteUs : 0)
              | (rq.wt ? PtePwt : 0) | (rq.cd ? PtePcd : 0);
        pg = rq.page;
        left = rq.count;
        rs.status = StDone;
        while (left != 0) begin
            big = (pg[8:0] == 0) && (left >= Slots);
            rs.status = map_leaf(pg, big, flags);
            if (rs.status != StDone) break;
            pg = pg + (big ? Slots : 1);
            left = left - (big ? Slots : 1);
        end
        rs.stop_page = pg;
        rs.pages_left = left;
        return rs;
    endfunction

    // driver: one beat in flight at most, next item offered after acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                rsp_q.push_back(map_range(cur_req));
                void'(req_q.pop_front());
            end
            if (req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                cur_req = req_q[0];
                if (cur_req.drain_first && (rsp_q.size() != 0 || (i_start && !o_busy))) begin
                    i_start <= 1'b0;
                end else begin
                    i_start <= 1'b1;
                    i_base_page <= cur_req.page;
                    i_page_count <= cur_req.count;
                    i_writable <= cur_req.wr;
                    i_user_access <= cur_req.us;
                    i_write_through <= cur_req.wt;
                    i_cache_disable <= cur_req.cd;
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_map_rsp want;
        if (i_rst_n && o_done) begin
            if (rsp_q.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                want = rsp_q.pop_front();
                if (o_status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, o_status);
                    errors++;
                end
                if (o_stop_page !== want.stop_page) begin
                    $error("stop_page exp %h got %h", want.stop_page, o_stop_page);
                    errors++;
                end
                if (o_pages_left !== want.pages_left) begin
                    $error("pages_left exp %h got %h", want.pages_left, o_pages_left);
                    errors++;
                end
            end
        end
    end

    task automatic add_req(input logic [PageW-1:0] pg, input logic [CountW-1:0] cnt,
                           input logic [3:0] fl, input bit drain);
        t_map_req rq;
        rq.page = pg;
        rq.count = cnt;
        {rq.wr, rq.us, rq.wt, rq.cd} = fl;
        rq.drain_first = drain;
        req_q.push_back(rq);
    endtask

    task automatic add_random(input int unsigned n, input bit spread);
        logic [PageW-1:0] pg;
        logic [CountW-1:0] cnt;
        logic [17:0] region [3] = '{18'h0, 18'h2aaaa, 18'h15555};
        int unsigned pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (spread && pick < 30) begin
                pg = {$urandom, $urandom} & 36'hf_ffff_ffff;
            end else begin
                // stay in a few directory windows so walks reuse the pool
                pg = {region[$urandom_range(2)], 9'(($urandom_range(4) == 4) ? 511 :
                      $urandom_range(3)), 9'($urandom_range(511))};
                if ($urandom_range(3) == 0) pg[8:0] = '0;
            end
            pick = $urandom_range(99);
            if (pick < 60) cnt = $urandom_range(20);
            else if (pick < 78) cnt = $urandom_range(3);
            else if (pick < 98) cnt = $urandom_range(1100, 500);
            else cnt = $urandom;
            add_req(pg, cnt, 4'($urandom), $urandom_range(199) == 0);
        end
    endtask

    task automatic wait_quiet();
        do @(posedge i_clk);
        while (req_q.size() != 0 || rsp_q.size() != 0 || i_start || o_busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pool_reg = value & Addr48;
    endtask

    initial begin
        for (int i = 0; i < Slots; i++) shadow_mem[i] = '0;
        tables_used = 1;
        pool_reg = '0;
        idle_pct = 9;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (o_busy);
        apb_write(64'h0);

        // directed
        add_req(36'h0, 20'h0, 4'hf, 0);
        add_req(36'h0, 20'h1, 4'hf, 0);
        add_req(36'h0, 20'h1, 4'h0, 0);          // already mapped
        add_req(36'd512, 20'd512, 4'ha, 0);      // one 2 MiB entry
        add_req(36'd513, 20'd1, 4'h5, 0);        // small walk meets large entry
        add_req(36'd1024, 20'd1, 4'h1, 0);
        add_req(36'd1024, 20'd512, 4'h2, 0);     // large slot already linked
        add_req(36'd1536, 20'd515, 4'h4, 0);
        add_req(36'd2048, 20'd0, 4'h8, 0);
        add_req(36'hf_ffff_ffff, 20'd3, 4'h3, 0); // wraps onto page 0
        add_req(36'hf_ffff_fffe, 20'hf_ffff, 4'hc, 1);
        add_req(36'd2560, 20'd40, 4'h9, 0);
        add_req(36'd2600, 20'd2, 4'h6, 0);
        add_random(420, 0);
        wait_quiet();

        // moved pool base turns existing links stale
        apb_write(64'hffff_ffff_ffff_ffff);
        idle_pct = 78;
        add_req(36'h0, 20'd1, 4'hf, 0);
        add_req(36'd3000, 20'd4, 4'h1, 0);
        add_random(200, 0);
        wait_quiet();

        apb_write(64'h0000_0000_0000_0fff);
        idle_pct = 0;
        add_random(450, 0);
        add_random(220, 1);                      // spread walks drain the pool
        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("page_table_identity_mapper_core_tb: PASS");
        else $display("page_table_identity_mapper_core_tb: FAIL");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("page_table_identity_mapper_core_tb: FAIL");
        $finish;
    end
endmodule
